@@ rtl/core/hit_coincidence_grouper_assert.svh @@
// Assertion macros shared by the hit coincidence grouper checkers.
`ifndef HIT_COINCIDENCE_GROUPER_ASSERT_SVH
`define HIT_COINCIDENCE_GROUPER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define HCG_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcg_checker: same-cycle property failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define HCG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcg_checker: next-cycle property failed");

`endif

@@ rtl/core/hcg_pkg.sv @@
// Package of widths, codes and item types for the hit coincidence grouper.
`default_nettype none

package hcg_pkg;

  localparam int TIME_W      = 48;
  localparam int ENERGY_W    = 16;
  localparam int ID_W        = 32;
  localparam int WINDOW_W    = 24;
  localparam int COUNT_W     = 32;
  localparam int MULT_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Default ceiling on the number of hits counted in one event.
  localparam int MAX_MULT_DEFAULT = 255;

  // Item operation codes.
  typedef enum logic {
    OP_HIT   = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOISE_THRESHOLD = 3'd0,
    CFG_START_THRESHOLD = 3'd1,
    CFG_TIME_WINDOW     = 3'd2,
    CFG_SEPARATE_BY_ID  = 3'd3,
    CFG_HITS_TREE       = 3'd4
  } cfg_idx_t;

  // Current configuration as seen by the event logic.
  typedef struct packed {
    logic [ENERGY_W-1:0] noise_threshold;
    logic [ENERGY_W-1:0] start_threshold;
    logic [WINDOW_W-1:0] window_len;
    logic                separate_by_id;
    logic                hits_tree_checks;
  } cfg_t;

  // One input item.
  typedef struct packed {
    op_t                 opcode;
    logic [TIME_W-1:0]   hit_time;
    logic [ENERGY_W-1:0] hit_energy;
    logic [ID_W-1:0]     event_id;
    logic                is_compton;
    logic                is_gamma;
  } hit_t;

  // One result item.
  typedef struct packed {
    logic               hit_kept;
    logic               started_event;
    logic               joined_event;
    logic               event_closed;
    logic [MULT_W-1:0]  closed_multiplicity;
    logic               closed_is_coincidence;
    logic [COUNT_W-1:0] compton_count;
    logic [COUNT_W-1:0] kept_count;
    logic [COUNT_W-1:0] started_count;
    logic [TIME_W-1:0]  run_span;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/hcg_event_core.sv @@
// Event grouping state and the single-pass decision logic for one item.
`default_nettype none

module hcg_event_core #(
  parameter int MAX_MULTIPLICITY = hcg_pkg::MAX_MULT_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  hcg_pkg::cfg_t    cfg,
  input  hcg_pkg::hit_t    hit,
  output hcg_pkg::result_t res
);

  import hcg_pkg::*;

  localparam int OSW = $clog2(MAX_MULTIPLICITY + 1);
  localparam int EXW = OSW + MULT_W;

  // Grouping state.
  logic [OSW-1:0]     open_size_r, open_size_nxt;
  logic [TIME_W-1:0]  win_time_r;
  logic [ID_W-1:0]    win_id_r;
  logic [TIME_W-1:0]  first_time_r;
  logic [TIME_W-1:0]  last_time_r;
  logic               any_kept_r, any_kept_nxt;
  logic [COUNT_W-1:0] compton_r, compton_nxt;
  logic [COUNT_W-1:0] kept_r, kept_nxt;
  logic [COUNT_W-1:0] started_r, started_nxt;

  logic              is_flush;
  logic              is_c;
  logic              kept;
  logic              above_start;
  logic              is_open;
  logic [TIME_W-1:0] dt;
  logic              in_window;
  logic              do_join;
  logic              do_close;
  logic              do_start;
  logic [EXW-1:0]    size_ext;
  logic [MULT_W-1:0] mult_sat;

  // Classify the item and decide join, close and start.
  always_comb begin
    is_flush    = (hit.opcode == OP_FLUSH);
    is_c        = !is_flush && (!cfg.hits_tree_checks || hit.is_compton);
    kept        = is_c && (hit.hit_energy > cfg.noise_threshold) &&
                  (!cfg.hits_tree_checks || hit.is_gamma);
    above_start = (hit.hit_energy > cfg.start_threshold);
    is_open     = (open_size_r != '0);
    dt          = hit.hit_time - win_time_r;
    if (cfg.separate_by_id) begin
      in_window = (hit.event_id == win_id_r);
    end else begin
      in_window = (hit.hit_time < win_time_r) ||
                  (dt < TIME_W'(cfg.window_len));
    end
    do_join  = kept && is_open && in_window;
    do_close = is_flush ? is_open : (kept && is_open && !in_window);
    do_start = kept && above_start && (!is_open || !in_window);
    size_ext = EXW'(open_size_r);
    mult_sat = (size_ext > EXW'(255)) ? {MULT_W{1'b1}} : size_ext[MULT_W-1:0];
  end

  // Next state.
  always_comb begin
    open_size_nxt = open_size_r;
    if (do_start) begin
      open_size_nxt = OSW'(1);
    end else if (do_close) begin
      open_size_nxt = '0;
    end else if (do_join && (open_size_r < OSW'(MAX_MULTIPLICITY))) begin
      open_size_nxt = open_size_r + OSW'(1);
    end
    any_kept_nxt = is_flush ? 1'b0 : (any_kept_r || kept);
    compton_nxt  = compton_r + COUNT_W'(is_c);
    kept_nxt     = kept_r + COUNT_W'(kept);
    started_nxt  = started_r + COUNT_W'(do_start);
  end

  // Result of this item; counts are the totals after it.
  always_comb begin
    res.hit_kept              = kept;
    res.started_event         = do_start;
    res.joined_event          = do_join;
    res.event_closed          = do_close;
    res.closed_multiplicity   = do_close ? mult_sat : '0;
    res.closed_is_coincidence = do_close && (size_ext >= EXW'(2));
    res.compton_count         = compton_nxt;
    res.kept_count            = kept_nxt;
    res.started_count         = started_nxt;
    res.run_span              = (is_flush && any_kept_r) ?
                                (last_time_r - first_time_r) : '0;
  end

  // Control state and running totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_size_r <= '0;
      any_kept_r  <= 1'b0;
      compton_r   <= '0;
      kept_r      <= '0;
      started_r   <= '0;
    end else if (adv) begin
      open_size_r <= open_size_nxt;
      any_kept_r  <= any_kept_nxt;
      compton_r   <= compton_nxt;
      kept_r      <= kept_nxt;
      started_r   <= started_nxt;
    end
  end

  // Window origin and run span times; read only once written.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (do_start) begin
        win_time_r <= hit.hit_time;
        win_id_r   <= hit.event_id;
      end
      if (kept) begin
        last_time_r <= hit.hit_time;
        if (!any_kept_r) begin
          first_time_r <= hit.hit_time;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hit_coincidence_grouper.sv @@
// Top level of the hit coincidence grouper.
// The block takes one item per clock on the in_ channel and gives exactly one
// result item per input item on the out_ channel, in order. An item is
// registered on entry, decided in a single pass by the event logic, and its
// result is registered before it is offered on out_; the sustained rate is
// one item per cycle while out_ready stays high, and the window compare and
// the event state update share that one pass. The input stalls only while
// both registers hold items and out_ready is low. Hits are kept if they pass
// the Compton, gamma and noise checks; a kept hit above the start threshold
// opens an event, later kept hits join while in the time window (or while
// the event id matches in id mode), and a flush closes any open event and
// reports the span of kept hit times. The user must write configuration
// through cfg_we, cfg_index and cfg_wdata only while no item is in flight;
// the block does not enforce this. The registers take effect on the following item.
`default_nettype none

module hit_coincidence_grouper #(
  parameter int MAX_MULTIPLICITY = hcg_pkg::MAX_MULT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hcg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [hcg_pkg::TIME_W-1:0]      in_hit_time,
  input  logic [hcg_pkg::ENERGY_W-1:0]    in_hit_energy,
  input  logic [hcg_pkg::ID_W-1:0]        in_event_id,
  input  logic                            in_is_compton,
  input  logic                            in_is_gamma,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit_kept,
  output logic                            out_started_event,
  output logic                            out_joined_event,
  output logic                            out_event_closed,
  output logic [hcg_pkg::MULT_W-1:0]      out_closed_multiplicity,
  output logic                            out_closed_is_coincidence,
  output logic [hcg_pkg::COUNT_W-1:0]     out_compton_count,
  output logic [hcg_pkg::COUNT_W-1:0]     out_kept_count,
  output logic [hcg_pkg::COUNT_W-1:0]     out_started_count,
  output logic [hcg_pkg::TIME_W-1:0]      out_run_span
);

  import hcg_pkg::*;

  cfg_t    cfg_r;
  logic    s1_valid_r;
  hit_t    s1_hit_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    s1_adv;
  logic    in_acc;

  // Handshake: the decision stage moves when the result register is free.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.noise_threshold  <= '0;
      cfg_r.start_threshold  <= '0;
      cfg_r.window_len       <= '0;
      cfg_r.separate_by_id   <= 1'b0;
      cfg_r.hits_tree_checks <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NOISE_THRESHOLD: cfg_r.noise_threshold  <= cfg_wdata[ENERGY_W-1:0];
        CFG_START_THRESHOLD: cfg_r.start_threshold  <= cfg_wdata[ENERGY_W-1:0];
        CFG_TIME_WINDOW:     cfg_r.window_len       <= cfg_wdata[WINDOW_W-1:0];
        CFG_SEPARATE_BY_ID:  cfg_r.separate_by_id   <= cfg_wdata[0];
        CFG_HITS_TREE:       cfg_r.hits_tree_checks <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hit_r.opcode     <= op_t'(in_opcode);
      s1_hit_r.hit_time   <= in_hit_time;
      s1_hit_r.hit_energy <= in_hit_energy;
      s1_hit_r.event_id   <= in_event_id;
      s1_hit_r.is_compton <= in_is_compton;
      s1_hit_r.is_gamma   <= in_is_gamma;
    end
  end

  // Event state and decision logic.
  hcg_event_core #(
    .MAX_MULTIPLICITY(MAX_MULTIPLICITY)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .cfg   (cfg_r),
    .hit   (s1_hit_r),
    .res   (res)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_hit_kept              = out_res_r.hit_kept;
  assign out_started_event         = out_res_r.started_event;
  assign out_joined_event          = out_res_r.joined_event;
  assign out_event_closed          = out_res_r.event_closed;
  assign out_closed_multiplicity   = out_res_r.closed_multiplicity;
  assign out_closed_is_coincidence = out_res_r.closed_is_coincidence;
  assign out_compton_count         = out_res_r.compton_count;
  assign out_kept_count            = out_res_r.kept_count;
  assign out_started_count         = out_res_r.started_count;
  assign out_run_span              = out_res_r.run_span;

endmodule

`default_nettype wire

@@ rtl/core/hcg_checker.sv @@
// Port-level checker for the hit coincidence grouper, bound to the top level.
`default_nettype none

`include "hit_coincidence_grouper_assert.svh"

module hcg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit_kept,
  input logic        out_started_event,
  input logic        out_joined_event,
  input logic        out_event_closed,
  input logic [7:0]  out_closed_multiplicity,
  input logic        out_closed_is_coincidence,
  input logic [31:0] out_compton_count,
  input logic [47:0] out_run_span
);

  // A stalled result stays offered and unchanged.
  `HCG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_compton_count) && $stable(out_run_span))

  // A hit either opens or joins, never both, only when kept, and a join closes nothing.
  `HCG_ASSERT_IMPLIES(a_hit_roles, out_valid, !(out_started_event && out_joined_event) && (!(out_started_event || out_joined_event) || out_hit_kept) && !(out_joined_event && out_event_closed))

  // A closed event holds at least one hit and is a coincidence from two hits on.
  `HCG_ASSERT_IMPLIES(a_close_fields, out_valid && out_event_closed, (out_closed_multiplicity != 8'd0) && (out_closed_is_coincidence == (out_closed_multiplicity >= 8'd2)))

  // Without a close the event fields read zero.
  `HCG_ASSERT_IMPLIES(a_quiet_fields, out_valid && !out_event_closed, (out_closed_multiplicity == 8'd0) && !out_closed_is_coincidence)

  // A run span is only reported by a flush, which keeps no hit.
  `HCG_ASSERT_IMPLIES(a_span_on_flush, out_valid && (out_run_span != 48'd0), !out_hit_kept && !out_started_event && !out_joined_event)

endmodule

bind hit_coincidence_grouper hcg_checker u_hcg_checker (.*);

`default_nettype wire
